[rtl/csc_pkg.sv]
// Shared constants, types and arithmetic helpers of the colour space converter.
package csc_pkg;

    localparam int SEC_W  = 3;
    localparam int CH_W   = 16;
    localparam int MODE_W = 3;

    localparam logic [15:0] FULL   = 16'hffff;
    localparam logic [15:0] HALF   = 16'h8000;
    localparam logic [15:0] LUMA_R = 16'h4c8b;
    localparam logic [15:0] LUMA_G = 16'h9646;
    localparam logic [15:0] LUMA_B = 16'h1d2f;

    localparam logic [2:0] MODE_RGB_HSV  = 3'd0;
    localparam logic [2:0] MODE_HSV_RGB  = 3'd1;
    localparam logic [2:0] MODE_RGB_HSL  = 3'd2;
    localparam logic [2:0] MODE_HSL_RGB  = 3'd3;
    localparam logic [2:0] MODE_HSV_HSL  = 3'd4;
    localparam logic [2:0] MODE_HSL_HSV  = 3'd5;
    localparam logic [2:0] MODE_RGB_LUMA = 3'd6;

    // quotient bits produced by the first and second divider chains
    localparam int D1_STEPS = 17;
    localparam int D2_STEPS = 32;

    typedef struct packed {
        logic [2:0]  sec;
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] v;
    } hsv_t;

    typedef struct packed {
        logic [15:0] rem;
        logic        q;
    } step_t;

    typedef struct packed {
        logic [2:0]  hsec;
        logic        dz;
        logic        vz;
        logic [15:0] v;
        logic [15:0] sp;
        logic [2:0]  sec;
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] luma;
    } front_t;

    typedef struct packed {
        hsv_t        hsv;
        logic [15:0] luma;
        logic [15:0] l;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] t;
        logic        ls;
    } back_t;

    // one restoring division step: shift in a dividend bit, subtract when it fits
    function automatic step_t div_step(logic [15:0] rem, logic nbit, logic [15:0] dv);
        logic [16:0] sh;
        logic [16:0] df;
        step_t       r;
        sh = {rem, nbit};
        df = sh - {1'b0, dv};
        if (sh >= {1'b0, dv})
        begin
            r.rem = df[15:0];
            r.q   = 1'b1;
        end
        else
        begin
            r.rem = sh[15:0];
            r.q   = 1'b0;
        end
        return r;
    endfunction

    // floor(x / 0xffff): estimate by x * (1 + 2^-16) / 2^16, then one correction
    function automatic logic [17:0] div_full(logic [33:0] x);
        logic [34:0] sm;
        logic [18:0] q1;
        logic [34:0] qm;
        logic [34:0] r;
        logic [18:0] qc;
        sm = {1'b0, x} + {17'b0, x[33:16]};
        q1 = sm[34:16];
        qm = {q1, 16'b0} - {16'b0, q1};
        r  = {1'b0, x} - qm;
        qc = (r >= {19'b0, FULL}) ? q1 + 19'd1 : q1;
        return qc[17:0];
    endfunction

endpackage

[rtl/csc_if.sv]
// Stream and configuration channel interfaces of the colour space converter.
interface csc_in_if;
    import csc_pkg::*;
    logic              valid;
    logic              ready;
    logic [SEC_W-1:0]  sector_in;
    logic [CH_W-1:0]   chan0;
    logic [CH_W-1:0]   chan1;
    logic [CH_W-1:0]   chan2;
    modport source (output valid, sector_in, chan0, chan1, chan2, input ready);
    modport sink   (input valid, sector_in, chan0, chan1, chan2, output ready);
endinterface

interface csc_out_if;
    import csc_pkg::*;
    logic              valid;
    logic              ready;
    logic [SEC_W-1:0]  sector_out;
    logic [CH_W-1:0]   out0;
    logic [CH_W-1:0]   out1;
    logic [CH_W-1:0]   out2;
    modport source (output valid, sector_out, out0, out1, out2, input ready);
    modport sink   (input valid, sector_out, out0, out1, out2, output ready);
endinterface

interface csc_cfg_if;
    import csc_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    modport source (output valid, mode, input ready);
    modport sink   (input valid, mode, output ready);
endinterface

[rtl/colour_space_converter.sv]
// Pipelined per-pixel RGB / HSV / HSL / luma converter, top level.
//
//   channel   dir  payload                               request taken when
//   pix_in    in   sector_in, chan0, chan1, chan2        valid && ready
//   pix_out   out  sector_out, out0, out1, out2          valid && ready
//   cfg       in   mode                                  valid (ready always high)
//
// One pixel per clock while no result waits unread at the output.
// Depth is set by two restoring divider chains, one quotient bit per stage:
// 17 stages for saturation / hue / value, 32 stages for the HSL saturation.
// Reset clears the stage valid bits and sets mode to RGB to HSV.
// While a result waits unread the whole pipeline holds; nothing is dropped.
module colour_space_converter (
    input  logic      clk,
    input  logic      rst_n,
    csc_in_if.sink    pix_in,
    csc_out_if.source pix_out,
    csc_cfg_if.sink   cfg
);
    import csc_pkg::*;

    localparam int N_STAGES = 4 + D1_STEPS + 4 + D2_STEPS + 1;

    logic [N_STAGES-1:0] vld_reg;
    logic [2:0]          mode_reg;
    logic                adv;
    logic                use_hsl;

    assign adv          = !vld_reg[N_STAGES-1] || pix_out.ready;
    assign pix_in.ready = adv;
    assign cfg.ready    = 1'b1;
    assign use_hsl      = (mode_reg == MODE_HSL_RGB) || (mode_reg == MODE_HSL_HSV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            mode_reg <= MODE_RGB_HSV;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[N_STAGES-2:0], pix_in.valid};
            end
            if (cfg.valid)
            begin
                mode_reg <= cfg.mode;
            end
        end
    end

    // ---------------- input register
    logic [2:0]  s0_sec_reg;
    logic [15:0] s0_c0_reg, s0_c1_reg, s0_c2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_sec_reg <= (pix_in.sector_in >= 3'd6) ? pix_in.sector_in - 3'd6
                                                     : pix_in.sector_in;
            s0_c0_reg  <= pix_in.chan0;
            s0_c1_reg  <= pix_in.chan1;
            s0_c2_reg  <= pix_in.chan2;
        end
    end

    // ---------------- max / min, HSL saturation product, luma products
    logic [15:0] a1_mx_next, a1_mn_next, mx01, mn01;
    logic [15:0] a1_v_reg, a1_mn_reg;
    logic [31:0] a1_prod_reg, a1_lr_reg, a1_lg_reg, a1_lb_reg;
    logic        a1_lhi_reg;
    logic [2:0]  a1_sec_reg;
    logic [15:0] a1_c0_reg, a1_c1_reg, a1_c2_reg;

    always_comb
    begin
        mx01       = (s0_c0_reg > s0_c1_reg) ? s0_c0_reg : s0_c1_reg;
        a1_mx_next = (mx01 > s0_c2_reg) ? mx01 : s0_c2_reg;
        mn01       = (s0_c0_reg < s0_c1_reg) ? s0_c0_reg : s0_c1_reg;
        a1_mn_next = (mn01 < s0_c2_reg) ? mn01 : s0_c2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_v_reg    <= a1_mx_next;
            a1_mn_reg   <= a1_mn_next;
            a1_prod_reg <= {16'b0, s0_c1_reg} * {16'b0, FULL - s0_c2_reg};
            a1_lhi_reg  <= s0_c2_reg >= HALF;
            a1_lr_reg   <= {16'b0, LUMA_R} * {16'b0, s0_c0_reg};
            a1_lg_reg   <= {16'b0, LUMA_G} * {16'b0, s0_c1_reg};
            a1_lb_reg   <= {16'b0, LUMA_B} * {16'b0, s0_c2_reg};
            a1_sec_reg  <= s0_sec_reg;
            a1_c0_reg   <= s0_c0_reg;
            a1_c1_reg   <= s0_c1_reg;
            a1_c2_reg   <= s0_c2_reg;
        end
    end

    // ---------------- delta, hue sector and numerator, HSL saturation, luma
    logic [15:0] a2_d_next, a2_num_next, a2_sp_next;
    logic [2:0]  a2_hsec_next;
    logic [17:0] a2_sdiv;
    logic [33:0] a2_lsum;
    logic [15:0] a2_d_reg, a2_num_reg, a2_sp_reg, a2_luma_reg, a2_v_reg;
    logic [2:0]  a2_hsec_reg, a2_sec_reg;
    logic [15:0] a2_c0_reg, a2_c1_reg, a2_c2_reg;

    always_comb
    begin
        a2_d_next = a1_v_reg - a1_mn_reg;
        priority if (a1_c0_reg == a1_v_reg)
        begin
            if (a1_c1_reg >= a1_c2_reg)
            begin
                a2_hsec_next = 3'd0;
                a2_num_next  = a1_c1_reg - a1_c2_reg;
            end
            else
            begin
                a2_hsec_next = 3'd5;
                a2_num_next  = a2_d_next + a1_c1_reg - a1_c2_reg;
            end
        end
        else if (a1_c1_reg == a1_v_reg)
        begin
            if (a1_c2_reg >= a1_c0_reg)
            begin
                a2_hsec_next = 3'd2;
                a2_num_next  = a1_c2_reg - a1_c0_reg;
            end
            else
            begin
                a2_hsec_next = 3'd1;
                a2_num_next  = a2_d_next + a1_c2_reg - a1_c0_reg;
            end
        end
        else
        begin
            if (a1_c0_reg >= a1_c1_reg)
            begin
                a2_hsec_next = 3'd4;
                a2_num_next  = a1_c0_reg - a1_c1_reg;
            end
            else
            begin
                a2_hsec_next = 3'd3;
                a2_num_next  = a2_d_next + a1_c0_reg - a1_c1_reg;
            end
        end
        a2_sdiv    = div_full({1'b0, a1_prod_reg, 1'b0});
        a2_sp_next = a1_lhi_reg ? a2_sdiv[15:0] : a1_c1_reg;
        a2_lsum    = {2'b0, a1_lr_reg} + {2'b0, a1_lg_reg} + {2'b0, a1_lb_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_d_reg    <= a2_d_next;
            a2_num_reg  <= a2_num_next;
            a2_hsec_reg <= a2_hsec_next;
            a2_sp_reg   <= a2_sp_next;
            a2_luma_reg <= a2_lsum[31:16];
            a2_v_reg    <= a1_v_reg;
            a2_sec_reg  <= a1_sec_reg;
            a2_c0_reg   <= a1_c0_reg;
            a2_c1_reg   <= a1_c1_reg;
            a2_c2_reg   <= a1_c2_reg;
        end
    end

    // ---------------- divider operands
    logic [31:0] a3_nx_reg, a3_ny_reg;
    logic [15:0] a3_dx_reg, a3_dy_reg;
    front_t      a3_fr_reg;
    front_t      a3_fr_next;

    always_comb
    begin
        a3_fr_next.hsec = a2_hsec_reg;
        a3_fr_next.dz   = a2_d_reg == 16'd0;
        a3_fr_next.vz   = a2_v_reg == 16'd0;
        a3_fr_next.v    = a2_v_reg;
        a3_fr_next.sp   = a2_sp_reg;
        a3_fr_next.sec  = a2_sec_reg;
        a3_fr_next.c0   = a2_c0_reg;
        a3_fr_next.c1   = a2_c1_reg;
        a3_fr_next.c2   = a2_c2_reg;
        a3_fr_next.luma = a2_luma_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a3_nx_reg <= use_hsl ? ({a2_c2_reg, 16'b0} - {16'b0, a2_c2_reg})
                                 : ({a2_d_reg, 16'b0} - {16'b0, a2_d_reg});
            a3_dx_reg <= use_hsl ? (FULL - {1'b0, a2_sp_reg[15:1]}) : a2_v_reg;
            a3_ny_reg <= {a2_num_reg, 16'b0} - {16'b0, a2_num_reg};
            a3_dy_reg <= a2_d_reg;
            a3_fr_reg <= a3_fr_next;
        end
    end

    // ---------------- first divider chain: x (saturation or value), y (hue)
    logic [15:0] d1_rx_reg [D1_STEPS];
    logic [15:0] d1_qx_reg [D1_STEPS];
    logic [15:0] d1_ry_reg [D1_STEPS];
    logic [15:0] d1_qy_reg [D1_STEPS];
    logic [15:0] d1_dx_reg [D1_STEPS];
    logic [15:0] d1_dy_reg [D1_STEPS];
    logic [31:0] d1_nx_reg [D1_STEPS];
    logic [31:0] d1_ny_reg [D1_STEPS];
    front_t      d1_fr_reg [D1_STEPS];

    for (genvar k = 0; k < D1_STEPS; k++)
    begin : g_d1
        logic [15:0] rx_in, qx_in, ry_in, qy_in, dx_in, dy_in;
        logic [31:0] nx_in, ny_in;
        front_t      fr_in;
        step_t       sx, sy;

        if (k == 0)
        begin : g_head
            assign rx_in = {1'b0, a3_nx_reg[31:D1_STEPS]};
            assign ry_in = {1'b0, a3_ny_reg[31:D1_STEPS]};
            assign qx_in = '0;
            assign qy_in = '0;
            assign dx_in = a3_dx_reg;
            assign dy_in = a3_dy_reg;
            assign nx_in = a3_nx_reg;
            assign ny_in = a3_ny_reg;
            assign fr_in = a3_fr_reg;
        end
        else
        begin : g_body
            assign rx_in = d1_rx_reg[k-1];
            assign ry_in = d1_ry_reg[k-1];
            assign qx_in = d1_qx_reg[k-1];
            assign qy_in = d1_qy_reg[k-1];
            assign dx_in = d1_dx_reg[k-1];
            assign dy_in = d1_dy_reg[k-1];
            assign nx_in = d1_nx_reg[k-1];
            assign ny_in = d1_ny_reg[k-1];
            assign fr_in = d1_fr_reg[k-1];
        end

        assign sx = div_step(rx_in, nx_in[D1_STEPS-1-k], dx_in);
        assign sy = div_step(ry_in, ny_in[D1_STEPS-1-k], dy_in);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_rx_reg[k] <= sx.rem;
                d1_qx_reg[k] <= {qx_in[14:0], sx.q};
                d1_ry_reg[k] <= sy.rem;
                d1_qy_reg[k] <= {qy_in[14:0], sy.q};
                d1_dx_reg[k] <= dx_in;
                d1_dy_reg[k] <= dy_in;
                d1_nx_reg[k] <= nx_in;
                d1_ny_reg[k] <= ny_in;
                d1_fr_reg[k] <= fr_in;
            end
        end
    end

    // ---------------- gather the hsv tuple for every mode
    front_t      p_fr;
    hsv_t        p_hsv_next;
    hsv_t        p_hsv_reg;
    logic [15:0] p_luma_reg;

    always_comb
    begin
        p_fr = d1_fr_reg[D1_STEPS-1];
        unique case (mode_reg)
            MODE_RGB_HSV, MODE_RGB_HSL:
            begin
                p_hsv_next.sec = p_fr.dz ? 3'd0 : p_fr.hsec;
                p_hsv_next.h   = p_fr.dz ? 16'd0 : d1_qy_reg[D1_STEPS-1];
                p_hsv_next.s   = p_fr.vz ? 16'd0 : d1_qx_reg[D1_STEPS-1];
                p_hsv_next.v   = p_fr.v;
            end
            MODE_HSL_RGB, MODE_HSL_HSV:
            begin
                p_hsv_next.sec = p_fr.sec;
                p_hsv_next.h   = p_fr.c0;
                p_hsv_next.s   = p_fr.sp;
                p_hsv_next.v   = d1_qx_reg[D1_STEPS-1];
            end
            default:
            begin
                p_hsv_next.sec = p_fr.sec;
                p_hsv_next.h   = p_fr.c0;
                p_hsv_next.s   = p_fr.c1;
                p_hsv_next.v   = p_fr.c2;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_hsv_reg  <= p_hsv_next;
            p_luma_reg <= p_fr.luma;
        end
    end

    // ---------------- products for lightness and for p, q, t
    logic [31:0] m1_ml_reg, m1_msh_reg, m1_mst_reg, m1_mp_reg;
    hsv_t        m1_hsv_reg;
    logic [15:0] m1_luma_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_ml_reg   <= {16'b0, p_hsv_reg.v} * {16'b0, FULL - {1'b0, p_hsv_reg.s[15:1]}};
            m1_msh_reg  <= {16'b0, p_hsv_reg.s} * {16'b0, p_hsv_reg.h};
            m1_mst_reg  <= {16'b0, p_hsv_reg.s} * {16'b0, FULL - p_hsv_reg.h};
            m1_mp_reg   <= {16'b0, p_hsv_reg.v} * {16'b0, FULL - p_hsv_reg.s};
            m1_hsv_reg  <= p_hsv_reg;
            m1_luma_reg <= p_luma_reg;
        end
    end

    // ---------------- divide by full scale
    logic [17:0] m2_l_div, m2_a_div, m2_b_div, m2_p_div;
    logic [15:0] m2_l_reg, m2_a_reg, m2_b_reg, m2_p_reg, m2_luma_reg;
    hsv_t        m2_hsv_reg;

    assign m2_l_div = div_full({2'b0, m1_ml_reg});
    assign m2_a_div = div_full({2'b0, m1_msh_reg});
    assign m2_b_div = div_full({2'b0, m1_mst_reg});
    assign m2_p_div = div_full({2'b0, m1_mp_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_l_reg    <= m2_l_div[15:0];
            m2_a_reg    <= m2_a_div[15:0];
            m2_b_reg    <= m2_b_div[15:0];
            m2_p_reg    <= m2_p_div[15:0];
            m2_hsv_reg  <= m1_hsv_reg;
            m2_luma_reg <= m1_luma_reg;
        end
    end

    // ---------------- q, t products and HSL saturation divider operands
    logic [31:0] m3_mq_reg, m3_mt_reg, m3_n2_reg;
    logic [15:0] m3_d2_reg, m3_l_reg, m3_p_reg, m3_luma_reg;
    logic [15:0] m3_fl;
    logic        m3_ls_reg;
    hsv_t        m3_hsv_reg;

    assign m3_fl = FULL - m2_l_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_mq_reg   <= {16'b0, m2_hsv_reg.v} * {16'b0, FULL - m2_a_reg};
            m3_mt_reg   <= {16'b0, m2_hsv_reg.v} * {16'b0, FULL - m2_b_reg};
            m3_n2_reg   <= {m2_hsv_reg.s, 16'b0} - {16'b0, m2_hsv_reg.s};
            m3_d2_reg   <= {m3_fl[14:0], 1'b0};
            m3_ls_reg   <= (m2_l_reg >= HALF) && (m2_l_reg != FULL);
            m3_l_reg    <= m2_l_reg;
            m3_p_reg    <= m2_p_reg;
            m3_hsv_reg  <= m2_hsv_reg;
            m3_luma_reg <= m2_luma_reg;
        end
    end

    // ---------------- second divider chain: HSL saturation
    logic [15:0] d2_r_reg  [D2_STEPS];
    logic [15:0] d2_q_reg  [D2_STEPS];
    logic [15:0] d2_dv_reg [D2_STEPS];
    logic [31:0] d2_n_reg  [D2_STEPS];
    back_t       d2_bk_reg [D2_STEPS];

    for (genvar k = 0; k < D2_STEPS; k++)
    begin : g_d2
        logic [15:0] r_in, q_in, dv_in;
        logic [31:0] n_in;
        back_t       bk_in;
        step_t       st;

        if (k == 0)
        begin : g_head
            logic [17:0] qf, tf;
            assign qf = div_full({2'b0, m3_mq_reg});
            assign tf = div_full({2'b0, m3_mt_reg});
            assign r_in  = '0;
            assign q_in  = '0;
            assign dv_in = m3_d2_reg;
            assign n_in  = m3_n2_reg;
            always_comb
            begin
                bk_in.hsv  = m3_hsv_reg;
                bk_in.luma = m3_luma_reg;
                bk_in.l    = m3_l_reg;
                bk_in.p    = m3_p_reg;
                bk_in.q    = qf[15:0];
                bk_in.t    = tf[15:0];
                bk_in.ls   = m3_ls_reg;
            end
        end
        else
        begin : g_body
            assign r_in  = d2_r_reg[k-1];
            assign q_in  = d2_q_reg[k-1];
            assign dv_in = d2_dv_reg[k-1];
            assign n_in  = d2_n_reg[k-1];
            assign bk_in = d2_bk_reg[k-1];
        end

        assign st = div_step(r_in, n_in[D2_STEPS-1-k], dv_in);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d2_r_reg[k]  <= st.rem;
                d2_q_reg[k]  <= {q_in[14:0], st.q};
                d2_dv_reg[k] <= dv_in;
                d2_n_reg[k]  <= n_in;
                d2_bk_reg[k] <= bk_in;
            end
        end
    end

    // ---------------- result selection
    back_t       f_bk;
    logic [15:0] f_r, f_g, f_b;
    logic [2:0]  f_sec_next;
    logic [15:0] f_o0_next, f_o1_next, f_o2_next;
    logic [2:0]  f_sec_reg;
    logic [15:0] f_o0_reg, f_o1_reg, f_o2_reg;

    always_comb
    begin
        f_bk = d2_bk_reg[D2_STEPS-1];
        if (f_bk.hsv.s == 16'd0)
        begin
            f_r = f_bk.hsv.v;
            f_g = f_bk.hsv.v;
            f_b = f_bk.hsv.v;
        end
        else
        begin
            unique case (f_bk.hsv.sec)
                3'd0:    begin f_r = f_bk.hsv.v; f_g = f_bk.t;     f_b = f_bk.p;     end
                3'd1:    begin f_r = f_bk.q;     f_g = f_bk.hsv.v; f_b = f_bk.p;     end
                3'd2:    begin f_r = f_bk.p;     f_g = f_bk.hsv.v; f_b = f_bk.t;     end
                3'd3:    begin f_r = f_bk.p;     f_g = f_bk.q;     f_b = f_bk.hsv.v; end
                3'd4:    begin f_r = f_bk.t;     f_g = f_bk.p;     f_b = f_bk.hsv.v; end
                default: begin f_r = f_bk.hsv.v; f_g = f_bk.p;     f_b = f_bk.q;     end
            endcase
        end

        unique case (mode_reg)
            MODE_RGB_HSV, MODE_HSL_HSV:
            begin
                f_sec_next = f_bk.hsv.sec;
                f_o0_next  = f_bk.hsv.h;
                f_o1_next  = f_bk.hsv.s;
                f_o2_next  = f_bk.hsv.v;
            end
            MODE_RGB_HSL, MODE_HSV_HSL:
            begin
                f_sec_next = f_bk.hsv.sec;
                f_o0_next  = f_bk.hsv.h;
                f_o1_next  = f_bk.ls ? d2_q_reg[D2_STEPS-1] : f_bk.hsv.s;
                f_o2_next  = f_bk.l;
            end
            MODE_HSV_RGB, MODE_HSL_RGB:
            begin
                f_sec_next = 3'd0;
                f_o0_next  = f_r;
                f_o1_next  = f_g;
                f_o2_next  = f_b;
            end
            MODE_RGB_LUMA:
            begin
                f_sec_next = 3'd0;
                f_o0_next  = f_bk.luma;
                f_o1_next  = 16'd0;
                f_o2_next  = 16'd0;
            end
            default:
            begin
                f_sec_next = 3'd0;
                f_o0_next  = 16'd0;
                f_o1_next  = 16'd0;
                f_o2_next  = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_sec_reg <= f_sec_next;
            f_o0_reg  <= f_o0_next;
            f_o1_reg  <= f_o1_next;
            f_o2_reg  <= f_o2_next;
        end
    end

    assign pix_out.valid      = vld_reg[N_STAGES-1];
    assign pix_out.sector_out = f_sec_reg;
    assign pix_out.out0       = f_o0_reg;
    assign pix_out.out1       = f_o1_reg;
    assign pix_out.out2       = f_o2_reg;

endmodule
